### rtl/mouth_coarticulation_smoother_core_macros.svh
// Assertion macros shared by the smoother RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef MOUTH_COARTICULATION_SMOOTHER_CORE_MACROS_SVH
`define MOUTH_COARTICULATION_SMOOTHER_CORE_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define MCS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mcs: assertion failed");

// Condition that must never be seen at a clock edge.
`define MCS_NEVER(lbl, cond) \
    `MCS_ASSERT(lbl, !(cond))

`endif

### rtl/mcs_pkg.sv
// Shared types and constants for the mouth coarticulation smoother.
// No dependencies; imported by every module of the block.
package mcs_pkg;

    localparam int CH_COUNT  = 5;
    localparam int LVL_W     = 9;     // Q8 level, 0..256
    localparam int DT_W      = 10;    // elapsed ms, 1..1000
    localparam int TAU_W     = 7;     // time constant in ms
    localparam int DEN_W     = 11;    // tau + dt
    localparam int ALPHA_W   = 8;     // dt*256/(tau+dt) < 256
    localparam int CAP_W     = 14;    // width of the tick cap
    localparam int DIV_STEPS = ALPHA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DT_W-1:0]  DT_DEFAULT_MS = 10'd33;
    localparam logic [31:0]      DT_CAP_TICKS  = 32'd16000;
    localparam logic [LVL_W-1:0] LEVEL_MAX     = 9'd256;
    localparam logic [LVL_W-1:0] WIDTH_PULL    = 9'd96;

    // channel order: open, width, round, press, teeth
    typedef logic [LVL_W-1:0] lvl_t;
    typedef logic [DT_W-1:0]  dt_t;
    typedef logic [TAU_W-1:0] tau_t;
    typedef logic [7:0]       byte_t;

    typedef lvl_t  [CH_COUNT-1:0] lvl_vec_t;
    typedef byte_t [CH_COUNT-1:0] byte_vec_t;
    typedef tau_t  [CH_COUNT-1:0] tau_vec_t;

    localparam tau_vec_t TAU_ATTACK  = {7'd60, 7'd22, 7'd55, 7'd70, 7'd45};
    localparam tau_vec_t TAU_RELEASE = {7'd60, 7'd55, 7'd65, 7'd70, 7'd95};
    localparam lvl_vec_t LEVEL_INIT  = {9'd0, 9'd0, 9'd30, 9'd110, 9'd0};

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_UPDATE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;     // pick tau, seed the divider
        logic step;     // one quotient bit
        logic update;   // apply the pole step to the level
    } lane_ctrl_t;

endpackage

### rtl/mcs_front.sv
// Keyframe front end: Q8 target scaling, dominance rules and elapsed time.
// Purely combinational; uses mcs_pkg.
module mcs_front (
    input  mcs_pkg::byte_vec_t raw,
    input  logic [31:0]        frame_time,
    input  logic [31:0]        prev_time,
    input  logic               has_frame,
    output mcs_pkg::lvl_vec_t  target,
    output mcs_pkg::dt_t       dt
);
    import mcs_pkg::*;

    lvl_t                q [CH_COUNT];
    logic [10:0]         press7;
    lvl_t                shade;
    logic [17:0]         open_prod;
    logic [10:0]         round3;
    logic [7:0]          pull;
    logic signed [9:0]   wdiff;
    logic signed [18:0]  wprod;
    logic signed [10:0]  wsum;
    logic                advanced;
    logic [31:0]         delta;
    logic [CAP_W-1:0]    capped;
    dt_t                 ms;

    always_comb
    begin
        // x*256/255 for a byte is x, plus one at full scale
        for (int i = 0; i < CH_COUNT; i++)
        begin
            q[i] = {1'b0, raw[i]} + {8'd0, (raw[i] == 8'hFF)};
        end

        // press closes the jaw
        press7    = 11'(q[3]) * 11'd7;
        shade     = LEVEL_MAX - {1'b0, press7[10:3]};
        open_prod = 18'(q[0]) * 18'(shade);

        // round pulls width toward 96
        round3 = 11'(q[2]) * 11'd3;
        pull   = round3[9:2];
        wdiff  = $signed({1'b0, WIDTH_PULL}) - $signed({1'b0, q[1]});
        wprod  = 19'(wdiff) * 19'($signed({1'b0, pull}));
        wsum   = $signed({2'b00, q[1]}) + wprod[18:8];

        target[0] = open_prod[16:8];
        target[1] = wsum[8:0];
        target[2] = q[2];
        target[3] = q[3];
        target[4] = q[4];

        advanced = has_frame && (frame_time > prev_time);
        delta    = frame_time - prev_time;
        capped   = (delta > DT_CAP_TICKS) ? DT_CAP_TICKS[CAP_W-1:0] : delta[CAP_W-1:0];
        ms       = capped[CAP_W-1:4];

        if (!advanced)
        begin
            dt = DT_DEFAULT_MS;
        end
        else if (ms == '0)
        begin
            dt = dt_t'(1);
        end
        else
        begin
            dt = ms;
        end
    end

endmodule

### rtl/mcs_lane.sv
// One smoothing channel: restoring divider for alpha and the level update.
// Uses mcs_pkg and the assertion macro header.
`include "mouth_coarticulation_smoother_core_macros.svh"

module mcs_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  mcs_pkg::lane_ctrl_t ctrl,
    input  mcs_pkg::lvl_t       target,
    input  mcs_pkg::dt_t        dt,
    input  mcs_pkg::tau_t       tau_attack,
    input  mcs_pkg::tau_t       tau_release,
    input  mcs_pkg::lvl_t       level_init,
    output mcs_pkg::lvl_t       level
);
    import mcs_pkg::*;

    lvl_t                level_reg, level_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [ALPHA_W-1:0]  quo_reg, quo_next;

    tau_t                tau_sel;
    logic [DEN_W:0]      rem_dbl;
    logic [DEN_W:0]      rem_sub;
    logic                fits;
    logic signed [9:0]   diff;
    logic signed [18:0]  prod;
    logic signed [10:0]  lsum;

    always_comb
    begin
        tau_sel = (target > level_reg) ? tau_attack : tau_release;
        rem_dbl = {rem_reg, 1'b0};
        rem_sub = rem_dbl - {1'b0, den_reg};
        fits    = (rem_dbl >= {1'b0, den_reg});

        // floor shift of (target - level) * alpha
        diff = $signed({1'b0, target}) - $signed({1'b0, level_reg});
        prod = 19'(diff) * 19'($signed({1'b0, quo_reg}));
        lsum = $signed({2'b00, level_reg}) + prod[18:8];

        level_next = level_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;

        if (ctrl.load)
        begin
            // dt < tau + dt, so dt starts as the remainder; the doubling steps form dt*256/(tau+dt)
            den_next = DEN_W'(tau_sel) + DEN_W'(dt);
            rem_next = DEN_W'(dt);
            quo_next = '0;
        end
        else if (ctrl.step)
        begin
            rem_next = fits ? rem_sub[DEN_W-1:0] : rem_dbl[DEN_W-1:0];
            quo_next = {quo_reg[ALPHA_W-2:0], fits};
        end

        if (ctrl.update)
        begin
            level_next = lsum[LVL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= level_init;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign level = level_reg;

    `MCS_NEVER(a_level_range, level_reg > LEVEL_MAX)

endmodule

### rtl/mcs_merge.sv
// Merging stage: Q8 levels of all lanes to bytes, held in the output register.
// Uses mcs_pkg.
module mcs_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mcs_pkg::lvl_vec_t   levels,
    input  logic                out_stall,
    output logic                out_valid,
    output mcs_pkg::byte_vec_t  bytes,
    output logic                free
);
    import mcs_pkg::*;

    logic       out_valid_reg, out_valid_next;
    byte_vec_t  bytes_reg, bytes_next;
    logic [16:0] scaled [CH_COUNT];

    always_comb
    begin
        // level*255/256; a level of at most 256 never exceeds 255
        for (int i = 0; i < CH_COUNT; i++)
        begin
            scaled[i]     = {levels[i], 8'd0} - 17'(levels[i]);
            bytes_next[i] = load ? scaled[i][15:8] : bytes_reg[i];
        end
        free           = !out_valid_reg || !out_stall;
        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    assign out_valid = out_valid_reg;
    assign bytes     = bytes_reg;

endmodule

### rtl/mouth_coarticulation_smoother_core.sv
// Mouth coarticulation smoother, top level: sequencer, clock state, five lanes.
// Depends on mcs_pkg, mcs_front, mcs_lane, mcs_merge and the macro header.
//
// Each request carries five mouth target bytes and a timestamp in 1/16 ms
// ticks; each yields one result of five smoothed bytes. A request is taken
// only while the block is idle, and after acceptance it passes these steps
// before the next one can be accepted: latch the shaped targets and the
// elapsed time, choose each channel's time constant, run the restoring
// divider in every lane that forms alpha one bit per cycle, update the level
// and hand the result to the output register. The five lanes run side by
// side, so the eight-step divider is the longest step unless output stalls.
// A result waiting in the output register does not hold off the next request;
// only a second result finding the register still stalled waits.
`include "mouth_coarticulation_smoother_core_macros.svh"

module mouth_coarticulation_smoother_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  target_open,
    input  logic [7:0]  target_width,
    input  logic [7:0]  target_round,
    input  logic [7:0]  target_press,
    input  logic [7:0]  target_teeth,
    input  logic [31:0] frame_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  smooth_open,
    output logic [7:0]  smooth_width,
    output logic [7:0]  smooth_round,
    output logic [7:0]  smooth_press,
    output logic [7:0]  smooth_teeth
);
    import mcs_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        prev_time_reg, prev_time_next;
    logic               has_frame_reg, has_frame_next;
    lvl_vec_t           target_reg, target_next;
    dt_t                dt_reg, dt_next;

    byte_vec_t          raw;
    lvl_vec_t           front_target;
    dt_t                front_dt;
    lvl_vec_t           levels;
    byte_vec_t          bytes;
    lane_ctrl_t         lane_ctrl;
    logic               accept;
    logic               merge_load;
    logic               merge_free;

    assign raw = {target_teeth, target_press, target_round, target_width, target_open};

    mcs_front u_front (
        .raw        (raw),
        .frame_time (frame_time),
        .prev_time  (prev_time_reg),
        .has_frame  (has_frame_reg),
        .target     (front_target),
        .dt         (front_dt)
    );

    for (genvar g = 0; g < CH_COUNT; g++)
    begin : g_lane
        mcs_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl),
            .target      (target_reg[g]),
            .dt          (dt_reg),
            .tau_attack  (TAU_ATTACK[g]),
            .tau_release (TAU_RELEASE[g]),
            .level_init  (LEVEL_INIT[g]),
            .level       (levels[g])
        );
    end

    mcs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (merge_load),
        .levels    (levels),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .bytes     (bytes),
        .free      (merge_free)
    );

    always_comb
    begin
        in_stall       = (state_reg != S_IDLE);
        accept         = in_valid && !in_stall;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        prev_time_next = prev_time_reg;
        has_frame_next = has_frame_reg;
        target_next    = target_reg;
        dt_next        = dt_reg;
        lane_ctrl      = '0;
        merge_load     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    target_next    = front_target;
                    dt_next        = front_dt;
                    prev_time_next = frame_time;
                    has_frame_next = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                lane_ctrl.load = 1'b1;
                cnt_next       = '0;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                lane_ctrl.step = 1'b1;
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                lane_ctrl.update = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT:
            begin
                if (merge_free)
                begin
                    merge_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            prev_time_reg <= '0;
            has_frame_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prev_time_reg <= prev_time_next;
            has_frame_reg <= has_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        dt_reg     <= dt_next;
    end

    assign smooth_open  = bytes[0];
    assign smooth_width = bytes[1];
    assign smooth_round = bytes[2];
    assign smooth_press = bytes[3];
    assign smooth_teeth = bytes[4];

    `MCS_ASSERT(a_accept_starts, (in_valid && !in_stall) |=> (state_reg == S_LOAD))
    `MCS_ASSERT(a_div_length, (state_reg == S_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=> (state_reg == S_UPDATE))
    `MCS_ASSERT(a_result_source, $rose(out_valid) |-> $past(state_reg == S_OUT))
    `MCS_ASSERT(a_dt_in_range, (state_reg == S_DIV) |-> (dt_reg != '0 && dt_reg <= dt_t'(1000)))

endmodule

### bench/tb_top.sv
// Self-checking bench for mouth_coarticulation_smoother_core: directed keyframes, then random ones.
// Needs mcs_pkg and the core RTL; the expected poses come from an in-bench one-pole smoother.
`timescale 1ns / 100ps

module tb_top;
    import mcs_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_FRAMES = 900;

    localparam int CH_OPEN  = 0;
    localparam int CH_WIDTH = 1;
    localparam int CH_ROUND = 2;
    localparam int CH_PRESS = 3;
    localparam int CH_TEETH = 4;

    localparam int DEFAULT_MS = 33;
    localparam logic [31:0] TICK_CAP = 32'd16000;
    localparam logic [31:0] TICKS_MS = 32'd16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  target_open = 8'd0;
    logic [7:0]  target_width = 8'd0;
    logic [7:0]  target_round = 8'd0;
    logic [7:0]  target_press = 8'd0;
    logic [7:0]  target_teeth = 8'd0;
    logic [31:0] frame_time = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  smooth_open;
    logic [7:0]  smooth_width;
    logic [7:0]  smooth_round;
    logic [7:0]  smooth_press;
    logic [7:0]  smooth_teeth;

    // smoother state held by the bench
    int          mouth_level [CH_COUNT];
    logic [31:0] last_stamp;
    bit          seen_frame;

    byte_vec_t   expected_poses [$];
    int          frames_sent;
    int          poses_checked;
    int          mismatches;
    int          cycle_count;
    int          stall_left;
    bit          bursts_on;
    logic [31:0] clock_now;

    mouth_coarticulation_smoother_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .target_open  (target_open),
        .target_width (target_width),
        .target_round (target_round),
        .target_press (target_press),
        .target_teeth (target_teeth),
        .frame_time   (frame_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .smooth_open  (smooth_open),
        .smooth_width (smooth_width),
        .smooth_round (smooth_round),
        .smooth_press (smooth_press),
        .smooth_teeth (smooth_teeth)
    );

    always #2 clk = ~clk;

    function automatic int q8_of(input byte_t b);
        return (int'(b) * 256) / 255;
    endfunction

    // time constants in ms; rising selects attack, otherwise release
    function automatic int tau_ms(input int ch, input bit rising);
        case (ch)
            CH_OPEN:  return rising ? 45 : 95;
            CH_WIDTH: return 70;
            CH_ROUND: return rising ? 55 : 65;
            CH_PRESS: return rising ? 22 : 55;
            default:  return 60;
        endcase
    endfunction

    function automatic string channel_name(input int ch);
        case (ch)
            CH_OPEN:  return "open";
            CH_WIDTH: return "width";
            CH_ROUND: return "round";
            CH_PRESS: return "press";
            default:  return "teeth";
        endcase
    endfunction

    function automatic void reset_smoother();
        mouth_level[CH_OPEN]  = 0;
        mouth_level[CH_WIDTH] = q8_of(8'd110);
        mouth_level[CH_ROUND] = q8_of(8'd30);
        mouth_level[CH_PRESS] = 0;
        mouth_level[CH_TEETH] = 0;
        last_stamp = 32'd0;
        seen_frame = 1'b0;
    endfunction

    function automatic byte_vec_t advance_pose(input byte_vec_t goals, input logic [31:0] stamp);
        int          goal [CH_COUNT];
        int          dt;
        int          rate;
        int          v;
        logic [31:0] gap;
        byte_vec_t   pose;
        for (int i = 0; i < CH_COUNT; i++)
        begin
            goal[i] = q8_of(goals[i]);
        end
        // press closes the jaw, round drags width toward 96
        goal[CH_OPEN] = (goal[CH_OPEN] * (256 - ((goal[CH_PRESS] * 7) >> 3))) >> 8;
        goal[CH_WIDTH] = goal[CH_WIDTH]
            + (((q8_of(8'd96) - goal[CH_WIDTH]) * (goal[CH_ROUND] * 3 / 4)) >>> 8);

        if (!seen_frame || stamp <= last_stamp)
        begin
            dt = DEFAULT_MS;
        end
        else
        begin
            gap = stamp - last_stamp;
            if (gap > TICK_CAP)
            begin
                gap = TICK_CAP;
            end
            dt = int'(gap / TICKS_MS);
            if (dt < 1)
            begin
                dt = 1;
            end
        end
        seen_frame = 1'b1;
        last_stamp = stamp;

        for (int i = 0; i < CH_COUNT; i++)
        begin
            rate = dt * 256 / (tau_ms(i, goal[i] > mouth_level[i]) + dt);
            mouth_level[i] = mouth_level[i] + (((goal[i] - mouth_level[i]) * rate) >>> 8);
            v = mouth_level[i] * 255 / 256;
            if (v < 0)
            begin
                v = 0;
            end
            if (v > 255)
            begin
                v = 255;
            end
            pose[i] = v[7:0];
        end
        return pose;
    endfunction

    // Called at a rising edge; returns at the edge the request is taken, or after an idle gap.
    task automatic send_keyframe(input byte_t t_open, input byte_t t_width,
                                 input byte_t t_round, input byte_t t_press,
                                 input byte_t t_teeth, input logic [31:0] stamp);
        byte_vec_t goals;
        goals = {t_teeth, t_press, t_round, t_width, t_open};
        in_valid     <= 1'b1;
        target_open  <= t_open;
        target_width <= t_width;
        target_round <= t_round;
        target_press <= t_press;
        target_teeth <= t_teeth;
        frame_time   <= stamp;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        expected_poses.push_back(advance_pose(goals, stamp));
        frames_sent++;
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic test_first_frame();
        // first frame uses the default step whatever the clock says
        send_keyframe(8'd200, 8'd255, 8'd0, 8'd0, 8'd255, 32'd1000);
        // clock standing still, then stepping back
        send_keyframe(8'd200, 8'd255, 8'd0, 8'd0, 8'd255, 32'd1000);
        send_keyframe(8'd10, 8'd0, 8'd40, 8'd0, 8'd5, 32'd900);
    endtask

    task automatic test_elapsed_time();
        send_keyframe(8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 32'd901);     // one tick, raised to 1 ms
        send_keyframe(8'd0, 8'd128, 8'd0, 8'd0, 8'd255, 32'd916);     // 15 ticks
        send_keyframe(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 32'd932);     // exactly 1 ms
        send_keyframe(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 32'd1204);    // 17 ms
        send_keyframe(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 32'd17204);  // at the cap
        send_keyframe(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 32'd33205);     // one past the cap
        send_keyframe(8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 32'hFFFF_FFFF); // huge jump
        send_keyframe(8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 32'd5);      // wrapped clock
    endtask

    task automatic test_target_extremes();
        clock_now = 32'd100000;
        repeat (3)
        begin
            clock_now = clock_now + TICK_CAP;
            send_keyframe(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, clock_now);
        end
        repeat (3)
        begin
            clock_now = clock_now + TICK_CAP;
            send_keyframe(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, clock_now);
        end
        clock_now = clock_now + 32'd528;
        send_keyframe(8'd255, 8'd0, 8'd255, 8'd255, 8'd0, clock_now);
        clock_now = clock_now + 32'd528;
        send_keyframe(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, clock_now);
        clock_now = clock_now + 32'd528;
        send_keyframe(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, clock_now);
        clock_now = clock_now + 32'd528;
        send_keyframe(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, clock_now);
    endtask

    function automatic byte_t pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 8'd0;
        end
        if (r < 20)
        begin
            return 8'd255;
        end
        return byte_t'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] next_stamp(input logic [31:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return prev + $urandom_range(16, 1600);
        end
        if (r < 80)
        begin
            return prev + $urandom_range(0, 15);
        end
        if (r < 88)
        begin
            return prev + $urandom_range(16001, 1000000);
        end
        if (r < 94)
        begin
            return prev - $urandom_range(0, 5000);
        end
        return $urandom;
    endfunction

    task automatic test_random_frames();
        byte_vec_t goals;
        int        segment;
        for (int i = 0; i < CH_COUNT; i++)
        begin
            goals[i] = pick_target();
        end
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            segment = n / 100;
            // one quiet stretch midway; the tail runs without any idling
            bursts_on = (segment != 3) && (segment < 7);
            // targets often held for a few frames so levels can settle
            if ($urandom_range(0, 2) == 0)
            begin
                for (int i = 0; i < CH_COUNT; i++)
                begin
                    goals[i] = pick_target();
                end
            end
            clock_now = next_stamp(clock_now);
            send_keyframe(goals[CH_OPEN], goals[CH_WIDTH], goals[CH_ROUND],
                          goals[CH_PRESS], goals[CH_TEETH], clock_now);
        end
    endtask

    // result side: random stall bursts while enabled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0 && bursts_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        byte_vec_t seen;
        byte_vec_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen = {smooth_teeth, smooth_press, smooth_round, smooth_width, smooth_open};
            if (expected_poses.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, seen);
                mismatches++;
            end
            else
            begin
                want = expected_poses.pop_front();
                for (int i = 0; i < CH_COUNT; i++)
                begin
                    if (seen[i] !== want[i])
                    begin
                        $display("%0t: smooth_%s mismatch, expected %0d, actual %0d",
                                 $time, channel_name(i), want[i], seen[i]);
                        mismatches++;
                    end
                end
                poses_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_poses.size());
            $display("mouth_coarticulation_smoother_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        frames_sent   = 0;
        poses_checked = 0;
        mismatches    = 0;
        cycle_count   = 0;
        bursts_on     = 1'b1;
        clock_now     = 32'd0;
        reset_smoother();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_frame();
        test_elapsed_time();
        test_target_extremes();
        test_random_frames();
        in_valid <= 1'b0;

        while (expected_poses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d keyframes (timing edge cases, target extremes, random clocks)",
                 frames_sent);
        $display("checked %0d smoothed poses, %0d field mismatches", poses_checked, mismatches);
        if (mismatches == 0 && expected_poses.size() == 0)
        begin
            $display("mouth_coarticulation_smoother_core regression: pass");
        end
        else
        begin
            $display("mouth_coarticulation_smoother_core regression: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/mcs_pkg.sv
rtl/mcs_front.sv
rtl/mcs_lane.sv
rtl/mcs_merge.sv
rtl/mouth_coarticulation_smoother_core.sv
bench/tb_top.sv
